// ----- design/gacc_pkg.sv -----
// Shared types, constants and the GF(2^128) multiply of the GHASH accumulator.
package gacc_pkg;

	localparam int GF_BITS    = 128;
	localparam int HALF_BITS  = 64;
	localparam int CFG_IDX_W  = 8;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 8'd1;

	typedef struct packed {
		logic [HALF_BITS-1:0] block_high;
		logic [HALF_BITS-1:0] block_low;
		logic                 first_block;
		logic                 last_block;
	} msg_t;

	typedef struct packed {
		logic [HALF_BITS-1:0] digest_high;
		logic [HALF_BITS-1:0] digest_low;
	} digest_t;

	typedef struct packed {
		logic                 wr_en;
		logic [CFG_IDX_W-1:0] wr_index;
		logic [HALF_BITS-1:0] wr_data;
	} cfg_wr_t;

	// Operation class of one queued block.
	typedef enum logic [1:0] {
		OP_CHAIN  = 2'b00,
		OP_START  = 2'b01,
		OP_END    = 2'b10,
		OP_SINGLE = 2'b11
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [GF_BITS-1:0] block;
	} qitem_t;

	// Bit-reflected GCM multiply: bit n of the field element is x[GF_BITS-1-n].
	// A full carryless product is formed and then folded twice with
	// x^128 = x^7 + x^2 + x + 1.
	function automatic logic [GF_BITS-1:0] gf128_mul(input logic [GF_BITS-1:0] x,
		input logic [GF_BITS-1:0] h);
		logic [GF_BITS-1:0]   a;
		logic [GF_BITS-1:0]   b;
		logic [2*GF_BITS-2:0] c;
		logic [GF_BITS+5:0]   f;
		logic [GF_BITS-1:0]   r;
		logic [GF_BITS-1:0]   z;
		for (int n = 0; n < GF_BITS; n++) begin
			a[n] = x[GF_BITS-1-n];
			b[n] = h[GF_BITS-1-n];
		end
		c = '0;
		for (int i = 0; i < GF_BITS; i++) begin
			for (int j = 0; j < GF_BITS; j++) begin
				c[i+j] = c[i+j] ^ (a[i] & b[j]);
			end
		end
		f = {6'b0, c[GF_BITS-1:0]};
		for (int k = GF_BITS; k < 2*GF_BITS-1; k++) begin
			f[k-GF_BITS]   = f[k-GF_BITS]   ^ c[k];
			f[k-GF_BITS+1] = f[k-GF_BITS+1] ^ c[k];
			f[k-GF_BITS+2] = f[k-GF_BITS+2] ^ c[k];
			f[k-GF_BITS+7] = f[k-GF_BITS+7] ^ c[k];
		end
		r = f[GF_BITS-1:0];
		for (int k = GF_BITS; k < GF_BITS+6; k++) begin
			r[k-GF_BITS]   = r[k-GF_BITS]   ^ f[k];
			r[k-GF_BITS+1] = r[k-GF_BITS+1] ^ f[k];
			r[k-GF_BITS+2] = r[k-GF_BITS+2] ^ f[k];
			r[k-GF_BITS+7] = r[k-GF_BITS+7] ^ f[k];
		end
		for (int n = 0; n < GF_BITS; n++) begin
			z[GF_BITS-1-n] = r[n];
		end
		return z;
	endfunction

endpackage

// ----- design/gacc_front.sv -----
// Front end: accepts message blocks, classifies them and queues them for the back end.
module gacc_front import gacc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   msg_valid,
	output logic   msg_ready,
	input  msg_t   msg,
	output logic   q_valid,
	input  logic   q_ready,
	output qitem_t q_item
);

	qitem_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;
	qitem_t             item_in;

	always_comb begin
		item_in.block = {msg.block_high, msg.block_low};
		case ({msg.last_block, msg.first_block})
			2'b00:   item_in.op = OP_CHAIN;
			2'b01:   item_in.op = OP_START;
			2'b10:   item_in.op = OP_END;
			2'b11:   item_in.op = OP_SINGLE;
			default: item_in.op = OP_CHAIN;
		endcase
	end

	assign msg_ready = (count_q != QCNT_W'(QDEPTH));
	assign push      = msg_valid & msg_ready;
	assign q_valid   = (count_q != '0);
	assign pop       = q_valid & q_ready;
	assign q_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on a lone push");

endmodule

// ----- design/gacc_back.sv -----
// Back end: hash key registers, accumulator with GF(2^128) multiply, digest output register.
module gacc_back import gacc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    q_valid,
	output logic    q_ready,
	input  qitem_t  q_item,
	output logic    digest_valid,
	input  logic    digest_ready,
	output digest_t digest
);

	logic [GF_BITS-1:0] key_q;
	logic [GF_BITS-1:0] acc_q;
	logic [GF_BITS-1:0] dig_q;
	logic               dig_valid_q;
	logic               seed;
	logic               emit;
	logic               out_free;
	logic               fire;
	logic [GF_BITS-1:0] sum;
	logic [GF_BITS-1:0] prod;

	always_comb begin
		seed = (q_item.op inside {OP_START, OP_SINGLE});
		emit = (q_item.op inside {OP_END, OP_SINGLE});
	end

	assign out_free = !dig_valid_q || digest_ready;
	// Only a block that produces a digest waits for the output register.
	assign q_ready  = !emit || out_free;
	assign fire     = q_valid & q_ready;
	assign sum      = (seed ? '0 : acc_q) ^ q_item.block;
	assign prod     = gf128_mul(sum, key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg.wr_en) begin
			case (cfg.wr_index)
				CFG_KEY_HIGH: key_q[GF_BITS-1:HALF_BITS] <= cfg.wr_data;
				CFG_KEY_LOW:  key_q[HALF_BITS-1:0]       <= cfg.wr_data;
				default:      key_q                      <= key_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			dig_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				acc_q <= prod;
			end
			if (fire && emit) begin
				dig_valid_q <= 1'b1;
			end else if (digest_ready) begin
				dig_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			dig_q <= prod;
		end
	end

	assign digest_valid       = dig_valid_q;
	assign digest.digest_high = dig_q[GF_BITS-1:HALF_BITS];
	assign digest.digest_low  = dig_q[HALF_BITS-1:0];

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |-> out_free)
		else $error("digest transfer overwrote a pending digest");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> acc_q == $past(acc_q))
		else $error("accumulator changed without a block");

	a_digest_acc: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> dig_valid_q && dig_q == acc_q)
		else $error("digest differs from the new accumulator");

endmodule

// ----- design/ghash_accumulator_unit.sv -----
// Top level of the GHASH accumulator: front-end queue, multiply back end, key port.
//
//   channel   direction  handshake                  payload
//   msg       in         msg_valid / msg_ready      msg (block_high, block_low, flags)
//   digest    out        digest_valid / digest_ready digest (digest_high, digest_low)
//   config    in         wr_en                      wr_index, wr_data
//
// Barring a digest stall, one block per cycle is sustained; the accumulator update (a
// 128x128 carryless multiply, reduction) is combinational and sets the clock period.
// digest_valid is registered and rises as the last block of a message leaves the queue.
// Reset clears the hash key, the accumulator, the two-entry queue and the digest valid.
// A held digest stalls only blocks that end a message; others keep flowing until
// the queue fills and msg_ready drops.
module ghash_accumulator_unit import gacc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	output logic                 msg_ready,
	input  msg_t                 msg,
	output logic                 digest_valid,
	input  logic                 digest_ready,
	output digest_t              digest,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [HALF_BITS-1:0] wr_data
);

	logic    q_valid;
	logic    q_ready;
	qitem_t  q_item;
	cfg_wr_t cfg;

	assign cfg.wr_en    = wr_en;
	assign cfg.wr_index = wr_index;
	assign cfg.wr_data  = wr_data;

	gacc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item)
	);

	gacc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

endmodule
